// ===== rtl/core/mnqs_pkg.sv =====
// shared types, constants and divide-by-100 helpers for the note quantizer
package mnqs_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int PCT_DIV       = 100;
  localparam int RCP_SHIFT     = 24;
  // ceil(2^24 / 100)
  localparam logic [17:0] RCP100 = 18'd167773;
  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_GRID      = 3'd0,
    REG_QLEN      = 3'd1,
    REG_STRENGTH  = 3'd2,
    REG_SWING     = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [13:0] span;      // two rasters
    logic [12:0] grid;
    logic [13:0] swing_off; // grid * swing / 100
    logic [6:0]  strength;
    logic [15:0] thresh;
  } snap_cfg_t;

  // floor(a / 100) or one more
  function automatic logic [14:0] div100_est(input logic [20:0] a);
    logic [38:0] p;
    p = {18'b0, a} * {21'b0, RCP100};
    return p[38:RCP_SHIFT];
  endfunction

  // take back the possible overshoot of the estimate
  function automatic logic [14:0] div100_fix(input logic [20:0] a, input logic [14:0] q);
    logic [21:0] back;
    back = {7'b0, q} * 22'(PCT_DIV);
    if (back > {1'b0, a}) return q - 15'd1;
    return q;
  endfunction

endpackage

// ===== rtl/core/midi_note_quantizer_swing_top.sv =====
// top level of the midi note quantizer with swing
// throughput: one item per cycle; a stalled output holds the whole pipeline
// the remainder by the swing cell runs four bits per stage in each snap unit
// reset: synchronous, clears valid bits and loads the register defaults
module midi_note_quantizer_swing_top #(
  parameter int TICK_BITS = mnqs_pkg::TICK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // event_tick[30:0], part_offset[61:31], note_length[92:62]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // new_event_tick[31:0], new_length[62:32], changed[63]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import mnqs_pkg::*;

  localparam int EB = ((TICK_BITS > 31) ? TICK_BITS : 31) + 2;

  logic [12:0] grid;
  logic        qlen;
  logic [6:0]  strength;
  logic [6:0]  swing;
  logic [15:0] thresh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid     <= 13'd384;
      qlen     <= 1'b0;
      strength <= 7'd100;
      swing    <= 7'd0;
      thresh   <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_GRID:      grid     <= cfg_data[12:0];
        REG_QLEN:      qlen     <= cfg_data[0];
        REG_STRENGTH:  strength <= cfg_data[6:0];
        REG_SWING:     swing    <= cfg_data[6:0];
        REG_THRESHOLD: thresh   <= cfg_data;
        default: ;
      endcase
    end
  end

  // swing offset settles through the product, estimate and fix registers after a write, long before an item needs it
  logic [20:0] sw_prod;
  logic [20:0] sw_prod_q;
  logic [14:0] sw_est;
  logic [14:0] sw_val;
  always_ff @(posedge clk) begin
    sw_prod   <= {8'b0, grid} * {14'b0, swing};
    sw_est    <= div100_est(sw_prod);
    sw_prod_q <= sw_prod;
    sw_val    <= div100_fix(sw_prod_q, sw_est);
  end

  snap_cfg_t cfg;
  assign cfg.span      = {grid, 1'b0};
  assign cfg.grid      = grid;
  assign cfg.swing_off = sw_val[13:0];
  assign cfg.strength  = strength;
  assign cfg.thresh    = thresh;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: absolute start modulo 2^TICK_BITS
  logic [31:0]           sum32;
  logic [TICK_BITS+31:0] sum_ext;
  logic                  v0;
  logic [TICK_BITS-1:0]  t0;
  logic [30:0]           po0, len0;

  assign sum32   = {1'b0, s_tdata[30:0]} + {1'b0, s_tdata[61:31]};
  assign sum_ext = {{TICK_BITS{1'b0}}, sum32};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      t0   <= sum_ext[TICK_BITS-1:0];
      po0  <= s_tdata[61:31];
      len0 <= s_tdata[92:62];
    end
  end

  logic               v1;
  logic signed [15:0] mv1;
  logic [61:0]        pay1;

  mnqs_snap_pipe #(.TW(TICK_BITS), .PW(62)) u_snap_start (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (v0),
    .in_tick  (t0),
    .in_pay   ({po0, len0}),
    .out_valid(v1),
    .out_move (mv1),
    .out_pay  (pay1)
  );

  // moved start and the note end, lifted by a cell multiple so it stays positive
  logic                 vc;
  logic signed [EB-1:0] beg_c;
  logic [EB-1:0]        end_c;
  logic signed [15:0]   mv1_c;
  logic [30:0]          po_c, len_c;
  logic signed [EB-1:0] beg_next;
  logic [TICK_BITS+EB-1:0] t_ext;
  logic [TICK_BITS-1:0] pay1_t;

  assign t_ext    = {{EB{1'b0}}, pay1_t};
  assign beg_next = $signed(t_ext[EB-1:0]) + EB'(mv1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v1;
    end
    if (en) begin
      beg_c <= beg_next;
      end_c <= beg_next + EB'({1'b0, pay1[30:0]}) + (EB'(cfg.span) << 15);
      mv1_c <= mv1;
      po_c  <= pay1[61:31];
      len_c <= pay1[30:0];
    end
  end

  // start tick travels beside the first unit
  logic [TICK_BITS-1:0] t_dly [0:(TICK_BITS+3)/4+4];
  assign t_dly[0] = t0;
  for (genvar i = 0; i < (TICK_BITS + 3) / 4 + 4; i++) begin : g_tdly
    always_ff @(posedge clk) begin
      if (en) t_dly[i+1] <= t_dly[i];
    end
  end
  assign pay1_t = t_dly[(TICK_BITS+3)/4+4];

  logic               v2;
  logic signed [15:0] mv2;
  logic [EB+77:0]     pay2;

  mnqs_snap_pipe #(.TW(EB), .PW(EB + 78)) u_snap_end (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (vc),
    .in_tick  (end_c),
    .in_pay   ({beg_c, mv1_c, po_c, len_c}),
    .out_valid(v2),
    .out_move (mv2),
    .out_pay  (pay2)
  );

  // length update, clamp, relative start
  logic signed [EB-1:0] beg_f;
  logic signed [15:0]   mv1_f;
  logic [30:0]          po_f, len_f;
  logic signed [32:0]   len_sum;
  logic [30:0]          len_out;
  logic [EB-1:0]        rel;

  always_comb begin
    beg_f   = $signed(pay2[EB+77:78]);
    mv1_f   = $signed(pay2[77:62]);
    po_f    = pay2[61:31];
    len_f   = pay2[30:0];
    len_sum = $signed({2'b0, len_f}) + (qlen ? 33'(mv2) : 33'sd0);
    if (len_sum <= 33'sd0) begin
      len_out = 31'd1;
    end else if (len_sum > $signed({2'b0, LEN_MAX})) begin
      len_out = LEN_MAX;
    end else begin
      len_out = len_sum[30:0];
    end
    rel = beg_f - EB'({1'b0, po_f});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v2;
    end
    if (en) begin
      m_tdata <= {(len_out != len_f) || (mv1_f != 16'sd0), len_out, rel[31:0]};
    end
  end

endmodule

// ===== rtl/core/mnqs_snap_pipe.sv =====
// pipelined snap unit: remainder by the cell, nearest grid point, scaled move
module mnqs_snap_pipe #(
  parameter int TW = 34,
  parameter int PW = 62
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  mnqs_pkg::snap_cfg_t  cfg,
  input  logic                 in_valid,
  input  logic [TW-1:0]        in_tick,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_valid,
  output logic signed [15:0]   out_move,
  output logic [PW-1:0]        out_pay
);
  import mnqs_pkg::*;

  localparam int NS = (TW + 3) / 4;
  localparam int NB = 4 * NS;

  // one remainder step over four bits, x stays below 16 cells
  function automatic logic [13:0] rem_step(input logic [13:0] r, input logic [3:0] nib,
                                           input logic [13:0] m);
    logic [17:0] x;
    logic [17:0] ms;
    x = {r, nib};
    for (int k = 3; k >= 0; k--) begin
      ms = {4'b0, m} << k;
      if (x >= ms) x = x - ms;
    end
    return x[13:0];
  endfunction

  logic [13:0]   rr [0:NS];
  logic [NB-1:0] xx [0:NS];
  logic [PW-1:0] pp [0:NS];
  logic          vv [0:NS];

  assign rr[0] = '0;
  assign xx[0] = NB'(in_tick);
  assign pp[0] = in_pay;
  assign vv[0] = in_valid;

  for (genvar i = 0; i < NS; i++) begin : g_rem
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else if (en) begin
        vv[i+1] <= vv[i];
      end
      if (en) begin
        rr[i+1] <= rem_step(rr[i], xx[i][NB-1-4*i -: 4], cfg.span);
        xx[i+1] <= xx[i];
        pp[i+1] <= pp[i];
      end
    end
  end

  // nearest of cell start, swung midpoint and next cell start
  logic signed [16:0] d2s;
  logic [15:0]        d2m;
  logic [13:0]        d3;
  logic signed [15:0] diff_next;
  logic [15:0]        diff_mag;
  logic [13:0]        rem;

  always_comb begin
    rem = rr[NS];
    d2s = $signed({4'b0, cfg.grid} + {3'b0, cfg.swing_off}) - $signed({3'b0, rem});
    d2m = d2s[16] ? 16'(-d2s) : d2s[15:0];
    d3  = cfg.span - rem;
    if (cfg.grid == '0) begin
      diff_next = '0;
    end else if ({2'b0, rem} <= d2m && rem <= d3) begin
      diff_next = -$signed({2'b0, rem});
    end else if (d2m <= {2'b0, d3}) begin
      diff_next = d2s[15:0];
    end else begin
      diff_next = $signed({2'b0, d3});
    end
    diff_mag = diff_next[15] ? 16'(-diff_next) : diff_next;
  end

  logic signed [15:0] diff;
  logic               big_d, big_m, big_q;
  logic [PW-1:0]      pay_d, pay_m, pay_q;
  logic               v_d, v_m, v_q;
  logic signed [23:0] prod;
  logic [20:0]        amag_m, amag_q;
  logic               neg_m, neg_q;
  logic [14:0]        qest;
  logic [14:0]        qfix;

  assign prod = diff * $signed({1'b0, cfg.strength});
  assign qfix = div100_fix(amag_q, qest);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d       <= 1'b0;
      v_m       <= 1'b0;
      v_q       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_d       <= vv[NS];
      v_m       <= v_d;
      v_q       <= v_m;
      out_valid <= v_q;
    end
    if (en) begin
      diff   <= diff_next;
      big_d  <= diff_mag > cfg.thresh;
      pay_d  <= pp[NS];
      neg_m  <= prod[23];
      amag_m <= prod[23] ? 21'(-prod) : prod[20:0];
      big_m  <= big_d;
      pay_m  <= pay_d;
      qest   <= div100_est(amag_m);
      amag_q <= amag_m;
      neg_q  <= neg_m;
      big_q  <= big_m;
      pay_q  <= pay_m;
      if (!big_q) begin
        out_move <= '0;
      end else if (neg_q) begin
        out_move <= -$signed({1'b0, qfix});
      end else begin
        out_move <= $signed({1'b0, qfix});
      end
      out_pay <= pay_q;
    end
  end

endmodule

// ===== rtl/core/mnqs_checker.sv =====
// port-level checks for the note quantizer, bound to the top level
module mnqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("stalled result item changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[62:32] != 31'd0)
    else $error("zero length result");

endmodule

bind midi_note_quantizer_swing_top mnqs_checker u_mnqs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ===== sim/tb.sv =====
// testbench for the midi note quantizer with swing: scoreboard against a snap predictor
module tb;
  import mnqs_pkg::*;

  localparam int LATENCY   = 28;
  localparam int LIMIT     = 400000;
  localparam int PER_PHASE = 60;

  typedef struct {
    logic [31:0] tick;
    logic [30:0] len;
    logic        changed;
  } note_res_t;

  class note_scoreboard;
    longint grid, qlen, strength, swing, thresh;
    note_res_t pending[$];
    int errors;

    function new();
      grid = 384; qlen = 0; strength = 100; swing = 0; thresh = 0; errors = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [15:0] v);
      case (r)
        REG_GRID:      grid = v[12:0];
        REG_QLEN:      qlen = v[0];
        REG_STRENGTH:  strength = v[6:0];
        REG_SWING:     swing = v[6:0];
        REG_THRESHOLD: thresh = v;
        default: ;
      endcase
    endfunction

    function longint magnitude(longint v);
      return v < 0 ? -v : v;
    endfunction

    // floor toward minus infinity
    function longint cell_start(longint t, longint m);
      longint q;
      q = t / m;
      if ((t % m) != 0 && t < 0) q = q - 1;
      return q * m;
    endfunction

    function longint nearest_point(longint t);
      longint c1, c2, c3, d1, d2, d3;
      if (grid == 0) return t;
      c1 = cell_start(t, 2 * grid);
      c2 = c1 + grid + (grid * swing) / 100;
      c3 = c1 + 2 * grid;
      d1 = magnitude(c1 - t); d2 = magnitude(c2 - t); d3 = magnitude(c3 - t);
      if (d1 <= d2 && d1 <= d3) return c1;
      if (d2 <= d3) return c2;
      return c3;
    endfunction

    function longint shift_by(longint d);
      if (magnitude(d) > thresh) return (d * strength) / 100;
      return 0;
    endfunction

    function void note_accepted(logic [30:0] ev, logic [30:0] po, logic [30:0] len0);
      longint b0, b, l, e, mv;
      note_res_t r;
      b0 = longint'(ev) + longint'(po);
      b  = b0 + shift_by(nearest_point(b0) - b0);
      l  = len0;
      e  = b + l;
      mv = shift_by(nearest_point(e) - e);
      if (qlen != 0) l = l + mv;
      if (l <= 0) l = 1;
      if (l > 64'sd2147483647) l = 64'sd2147483647;
      r.tick = 32'(b - longint'(po));
      r.len = l[30:0];
      r.changed = (l != longint'(len0)) || (b != b0);
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] d);
      note_res_t x;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (d[31:0] !== x.tick) begin
        $error("new_event_tick exp %h got %h", x.tick, d[31:0]); errors++;
      end
      if (d[62:32] !== x.len) begin
        $error("new_length exp %h got %h", x.len, d[62:32]); errors++;
      end
      if (d[63] !== x.changed) begin
        $error("changed exp %b got %b", x.changed, d[63]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [95:0] s_tdata = '0;
  logic [63:0] m_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  bit long_hold = 0;
  int cycles = 0;
  note_scoreboard sb = new();

  always #5 clk = ~clk;

  midi_note_quantizer_swing_top DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_note(logic [30:0] ev, logic [30:0] po, logic [30:0] len);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b0, len, po, ev};
    do @(posedge clk); while (!s_tready);
    sb.note_accepted(ev, po, len);
  endtask

  // valid stays up across back to back writes, the caller drops it
  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    cfg_valid <= 1;
    cfg_addr <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_field(int mode);
    case (mode)
      0: return 31'($urandom_range(0, 20000));
      1: return 31'($urandom());
      2: return 31'h7FFF_FFFF - 31'($urandom_range(0, 50));
      default: return 31'($urandom_range(0, 3000000));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off when asked
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = long_hold ? 300 : $urandom_range(0, 3);
      if (long_hold) long_hold = 0;
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
    end
  end

  initial begin
    logic [15:0] phase_cfg[$][5];
    int m;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed at reset defaults: ties, extremes, zero length, wrap of the sum
    send_note(0, 0, 0);
    send_note(192, 0, 10);
    send_note(384, 0, 384);
    send_note(576, 0, 1);
    send_note(768, 0, 100);
    send_note(191, 1, 5);
    send_note(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_note(31'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
    send_note(0, 31'h7FFF_FFFF, 0);
    send_note(31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAA);
    send_note(31'h2AAA_AAAA, 31'h5555_5555, 31'h5555_5555);
    drain();

    // grid, qlen, strength, swing, threshold
    phase_cfg.push_back('{16'd384, 16'd1, 16'd100, 16'd0, 16'd0});
    phase_cfg.push_back('{16'd1, 16'd1, 16'd127, 16'd127, 16'd0});
    phase_cfg.push_back('{16'd6144, 16'd1, 16'd50, 16'd100, 16'd100});
    phase_cfg.push_back('{16'd0, 16'd1, 16'd100, 16'd50, 16'd0});
    phase_cfg.push_back('{16'd96, 16'd0, 16'd0, 16'd33, 16'd65535});
    phase_cfg.push_back('{16'd8191, 16'd1, 16'd127, 16'd66, 16'd10});
    phase_cfg.push_back('{16'd7, 16'd1, 16'd75, 16'd127, 16'd2});

    foreach (phase_cfg[p]) begin
      write_reg(REG_GRID, phase_cfg[p][0]);
      write_reg(REG_QLEN, phase_cfg[p][1]);
      write_reg(REG_STRENGTH, phase_cfg[p][2]);
      write_reg(REG_SWING, phase_cfg[p][3]);
      write_reg(REG_THRESHOLD, phase_cfg[p][4]);
      cfg_valid <= 0;
      if (p == 0) begin
        // fill the pipeline against a stalled output
        long_hold = 1;
        repeat (60) send_note(pick_field(0), pick_field(0), pick_field(0));
      end
      send_note(0, 0, 0);
      send_note(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      repeat (PER_PHASE) begin
        m = $urandom_range(0, 9);
        send_note(pick_field(m % 4), pick_field(m < 7 ? 0 : m % 4), pick_field((m + 1) % 4));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
